// ===== rtl/area_average_image_resize_assert.svh =====
// Assertion macros for the area average resizer
`ifndef AREA_AVERAGE_IMAGE_RESIZE_ASSERT_SVH
`define AREA_AVERAGE_IMAGE_RESIZE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define AAIR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define AAIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/aair_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aair_pkg
// Types and constants shared by the area average resizer.
// ----------------------------------------------------------------------------
package aair_pkg;

	localparam int MAX_DIM_DEF   = 128;
	localparam int MAX_CELLS_DEF = 16384;

	localparam int DIM_W = 8;
	localparam int PIX_W = 24;
	localparam int SUM_W = 22;
	localparam int CNT_W = 15;
	localparam int REG_IDX_W = 3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SRC_ROWS   = 3'd0,
		REG_SRC_COLS   = 3'd1,
		REG_DST_ROWS   = 3'd2,
		REG_DST_COLS   = 3'd3,
		REG_COLOR_MODE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             opcode;
		logic [PIX_W-1:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             out_last;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] r;
	} cell_t;

endpackage
`default_nettype wire

// ===== rtl/area_average_image_resize.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// area_average_image_resize
// Box filter resizer: accumulates source pixels into target cells, then
// reads out each cell as its sums divided by its hit count.
// ----------------------------------------------------------------------------
//  port      dir  handshake           carries
//  in_*      in   in_valid/in_stall   opcode, pixel_value
//  out_*     out  out_valid/out_stall out_pixel, out_last
//  cfg_*     in   cfg_we              register index and value
//
//  A load runs four divisions on the shared divider (start row, start col,
//  end row, end col), then a read and a write of each target cell it
//  covers, with a multiply at the start of each target row.
//  A read adds one division per channel (3 in color, 1 in gray) when the
//  cell has hits; the single shared divider runs them one after another.
//  After reset and after the last target pixel, a clearing pass writes zero
//  to all MAX_CELLS entries, one per cycle, while in_stall stays high.
//  A stalled result waits in the output register; the sequencer holds in
//  its output state only when a second result is ready behind it.
// ----------------------------------------------------------------------------
`include "area_average_image_resize_assert.svh"

module area_average_image_resize
	import aair_pkg::*;
#(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int MAX_CELLS = MAX_CELLS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data
);

	localparam int PW  = $clog2(MAX_DIM + 1);
	localparam int AW  = $clog2(MAX_CELLS);
	localparam int RIW = $clog2(MAX_CELLS + 1);
	localparam int IW  = 2 * DIM_W + 1;
	localparam int CELL_W = $bits(cell_t);

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_DGO   = 10'b0000000100,
		S_DWAIT = 10'b0000001000,
		S_CSET  = 10'b0000010000,
		S_CMUL  = 10'b0000100000,
		S_CRD   = 10'b0001000000,
		S_CWR   = 10'b0010000000,
		S_RMUL  = 10'b0100000000,
		S_RCHK  = 10'b1000000000
	} state_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end
		if (32'(v) > 32'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return v;
	endfunction

	state_t            state_q;
	logic              rmem_q;
	logic              out_st_q;
	logic [DIM_W-1:0]  src_rows_q, src_cols_q, dst_rows_q, dst_cols_q;
	logic              color_q;
	logic [DIM_W-1:0]  sr, sc, dr, dc;
	logic [PW-1:0]     row_q, col_q;
	logic [RIW-1:0]    read_index_q;
	logic [AW-1:0]     clr_idx_q;
	logic              op_q;
	logic [1:0]        step_q;
	logic [DIM_W-1:0]  ch_r_q, ch_g_q, ch_b_q;
	logic [DIM_W-1:0]  ir_q, ic_q, tr_q, tc_q, re_q, ce_q, zr_q, zc_q;
	logic [2*DIM_W-1:0] prod_q;
	logic [DIM_W-1:0]  mul_a, mul_b;
	logic [2*DIM_W-1:0] mul_p;
	logic [IW-1:0]     cell_idx;
	logic              cell_ok;
	logic              cell_ok_q;
	logic [AW-1:0]     addr_q;
	cell_t             ent_q;
	cell_t             rd_ent;
	logic [CELL_W-1:0] ram_rdata;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	cell_t             ram_wdata;
	logic              div_start, div_done;
	logic [SUM_W-1:0]  div_dividend, div_quotient;
	logic [CNT_W-1:0]  div_divisor;
	logic [DIM_W-1:0]  div_byte;
	logic [PIX_W-1:0]  res_q;
	logic              last_q;
	logic              out_valid_q;
	out_item_t         out_data_q;
	logic              out_free;
	logic              in_xfer;
	logic [1:0]        last_step;
	logic [DIM_W-1:0]  re_lim, ce_lim;
	logic              up_scale;
	logic              rd_bad;

	assign sr = eff_dim(src_rows_q);
	assign sc = eff_dim(src_cols_q);
	assign dr = eff_dim(dst_rows_q);
	assign dc = eff_dim(dst_cols_q);

	assign in_stall = (state_q != S_IDLE) || rmem_q || out_st_q;
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign last_step = color_q ? 2'd2 : 2'd0;

	// shared multiplier operand select
	always_comb begin
		mul_a = dr;
		mul_b = dc;
		if (state_q == S_DGO) begin
			case (step_q)
				2'd0:    begin mul_a = DIM_W'(row_q);         mul_b = dr; end
				2'd1:    begin mul_a = DIM_W'(col_q);         mul_b = dc; end
				2'd2:    begin mul_a = DIM_W'(row_q) + 1'b1;  mul_b = dr; end
				default: begin mul_a = DIM_W'(col_q) + 1'b1;  mul_b = dc; end
			endcase
		end else if (state_q == S_CMUL) begin
			mul_a = zr_q;
			mul_b = dc;
		end
	end
	assign mul_p = mul_a * mul_b;

	// divider operand select
	always_comb begin
		if (op_q == OP_READ) begin
			case (step_q)
				2'd0:    div_dividend = ent_q.r;
				2'd1:    div_dividend = ent_q.g;
				default: div_dividend = ent_q.b;
			endcase
			div_divisor = ent_q.cnt;
		end else begin
			div_dividend = SUM_W'(mul_p);
			div_divisor  = step_q[0] ? CNT_W'(sc) : CNT_W'(sr);
		end
	end
	assign div_start = (state_q == S_DGO) && !rmem_q && !out_st_q;
	assign div_byte  = (div_quotient > SUM_W'(255)) ? DIM_W'(255) : div_quotient[DIM_W-1:0];

	aair_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign cell_idx = IW'(prod_q) + IW'(zc_q);
	assign cell_ok  = 32'(cell_idx) < 32'(MAX_CELLS);
	assign rd_bad   = (32'(read_index_q) >= 32'(prod_q)) ||
	                  (32'(read_index_q) >= 32'(MAX_CELLS));
	assign rd_ent   = cell_t'(ram_rdata);

	assign re_lim   = (tr_q < dr) ? tr_q : dr;
	assign ce_lim   = (tc_q < dc) ? tc_q : dc;
	assign up_scale = (dr > sr) || (dc > sc);

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = AW'(read_index_q);
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
		end else if (state_q == S_CWR && cell_ok_q) begin
			ram_we      = 1'b1;
			ram_wdata.r = rd_ent.r + SUM_W'(ch_r_q);
			ram_wdata.g = rd_ent.g + SUM_W'(ch_g_q);
			ram_wdata.b = rd_ent.b + SUM_W'(ch_b_q);
			ram_wdata.cnt = rd_ent.cnt + 1'b1;
		end
		if (state_q == S_CRD && cell_ok) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(cell_idx);
		end else if (state_q == S_RCHK && !rd_bad) begin
			ram_re = 1'b1;
		end
	end

	aair_ram #(
		.WIDTH (CELL_W),
		.DEPTH (MAX_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rows_q <= DIM_W'(128);
			src_cols_q <= DIM_W'(128);
			dst_rows_q <= DIM_W'(128);
			dst_cols_q <= DIM_W'(128);
			color_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_ROWS:   src_rows_q <= cfg_data;
				REG_SRC_COLS:   src_cols_q <= cfg_data;
				REG_DST_ROWS:   dst_rows_q <= cfg_data;
				REG_DST_COLS:   dst_cols_q <= cfg_data;
				REG_COLOR_MODE: color_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			rmem_q       <= 1'b0;
			out_st_q     <= 1'b0;
			clr_idx_q    <= '0;
			row_q        <= '0;
			col_q        <= '0;
			read_index_q <= '0;
			op_q         <= OP_LOAD;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !(out_st_q && out_free)) begin
				out_valid_q <= 1'b0;
			end
			if (out_st_q) begin
				// hand the result to the output register
				if (out_free) begin
					out_valid_q <= 1'b1;
					out_st_q    <= 1'b0;
					if (last_q) begin
						row_q        <= '0;
						col_q        <= '0;
						read_index_q <= '0;
						clr_idx_q    <= '0;
						state_q      <= S_CLEAR;
					end else begin
						state_q <= S_IDLE;
					end
				end
			end else if (rmem_q) begin
				rmem_q <= 1'b0;
				if (rd_ent.cnt == '0) begin
					out_st_q <= 1'b1;
				end else begin
					step_q  <= '0;
					state_q <= S_DGO;
				end
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_idx_q <= clr_idx_q + 1'b1;
						if (clr_idx_q == AW'(MAX_CELLS - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_xfer) begin
							op_q   <= in_data.opcode;
							step_q <= '0;
							if (in_data.opcode == OP_READ) begin
								state_q <= S_RMUL;
							end else if (32'(row_q) >= 32'(sr)) begin
								state_q <= S_IDLE;
							end else if (32'(col_q) >= 32'(sc)) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								state_q <= S_DGO;
							end
						end
					end
					S_DGO: state_q <= S_DWAIT;
					S_DWAIT: begin
						if (div_done) begin
							step_q <= step_q + 1'b1;
							if (op_q == OP_READ) begin
								if (step_q == last_step) begin
									out_st_q <= 1'b1;
									state_q  <= S_IDLE;
								end else begin
									state_q <= S_DGO;
								end
							end else if (step_q == 2'd3) begin
								state_q <= S_CSET;
							end else begin
								state_q <= S_DGO;
							end
						end
					end
					S_CSET: state_q <= S_CMUL;
					S_CMUL: state_q <= S_CRD;
					S_CRD:  state_q <= S_CWR;
					S_CWR: begin
						if (zc_q + 1'b1 < ce_q) begin
							state_q <= S_CRD;
						end else if (zr_q + 1'b1 < re_q) begin
							state_q <= S_CMUL;
						end else begin
							// pixel done: advance the source position
							state_q <= S_IDLE;
							if (32'(col_q) + 32'd1 >= 32'(sc)) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
					S_RMUL: state_q <= S_RCHK;
					S_RCHK: begin
						state_q <= S_IDLE;
						if (rd_bad) begin
							out_st_q <= 1'b1;
						end else begin
							rmem_q       <= 1'b1;
							read_index_q <= read_index_q + 1'b1;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (color_q) begin
				ch_r_q <= in_data.pixel_value[23:16];
				ch_g_q <= in_data.pixel_value[15:8];
				ch_b_q <= in_data.pixel_value[7:0];
			end else begin
				ch_r_q <= in_data.pixel_value[7:0];
				ch_g_q <= '0;
				ch_b_q <= '0;
			end
		end
		if (state_q == S_DWAIT && div_done) begin
			if (op_q == OP_READ) begin
				if (!color_q) begin
					res_q[7:0] <= div_byte;
				end else begin
					case (step_q)
						2'd0:    res_q[23:16] <= div_byte;
						2'd1:    res_q[15:8]  <= div_byte;
						default: res_q[7:0]   <= div_byte;
					endcase
				end
			end else begin
				case (step_q)
					2'd0:    ir_q <= div_quotient[DIM_W-1:0];
					2'd1:    ic_q <= div_quotient[DIM_W-1:0];
					2'd2:    tr_q <= div_quotient[DIM_W-1:0];
					default: tc_q <= div_quotient[DIM_W-1:0];
				endcase
			end
		end
		if (state_q == S_CSET) begin
			zr_q <= ir_q;
			zc_q <= ic_q;
			if (up_scale && re_lim > ir_q && ce_lim > ic_q) begin
				re_q <= re_lim;
				ce_q <= ce_lim;
			end else begin
				re_q <= ir_q + 1'b1;
				ce_q <= ic_q + 1'b1;
			end
		end
		if (state_q == S_CMUL || state_q == S_RMUL) begin
			prod_q <= mul_p;
		end
		if (state_q == S_CRD) begin
			addr_q    <= AW'(cell_idx);
			cell_ok_q <= cell_ok;
		end
		if (state_q == S_CWR && !rmem_q && !out_st_q) begin
			if (zc_q + 1'b1 < ce_q) begin
				zc_q <= zc_q + 1'b1;
			end else begin
				zc_q <= ic_q;
				zr_q <= zr_q + 1'b1;
			end
		end
		if (state_q == S_RCHK && !rmem_q && !out_st_q) begin
			res_q  <= '0;
			last_q <= rd_bad || (32'(read_index_q) + 32'd1 == 32'(prod_q));
		end
		if (rmem_q && !out_st_q) begin
			ent_q <= rd_ent;
		end
		if (out_st_q && out_free) begin
			out_data_q.out_pixel <= res_q;
			out_data_q.out_last  <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`AAIR_ASSERT_NOW(a_div_done_wait, div_done, state_q == S_DWAIT, "divider result outside wait")
	`AAIR_ASSERT_NOW(a_ram_we_state, ram_we, state_q == S_CLEAR || state_q == S_CWR, "stray write")
	`AAIR_ASSERT_NEXT(a_out_load, !out_valid_q && !out_st_q, !out_valid_q, "result from nowhere")

endmodule
`default_nettype wire

// ===== rtl/aair_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aair_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module aair_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/aair_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aair_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aair_div
	import aair_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0] divisor,
	output logic                  done,
	output logic      [SUM_W-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== sim/tb_area_average_image_resize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_area_average_image_resize
// Self-checking bench for the area average resizer. It streams small images
// through load and read-out under several register settings and compares
// every target pixel with a cycle-free model of cell sums and hit counts.
// ----------------------------------------------------------------------------
module tb_area_average_image_resize;
	import aair_pkg::*;

	localparam int CELLS = MAX_CELLS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	area_average_image_resize u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// resize state as seen from outside
	logic [SUM_W-1:0] red_acc [CELLS];
	logic [SUM_W-1:0] grn_acc [CELLS];
	logic [SUM_W-1:0] blu_acc [CELLS];
	logic [CNT_W-1:0] hit_acc [CELLS];
	int unsigned row_pos, col_pos, rd_pos;
	logic [DIM_W-1:0] m_src_rows = 8'd128, m_src_cols = 8'd128;
	logic [DIM_W-1:0] m_dst_rows = 8'd128, m_dst_cols = 8'd128;
	logic m_color = 1'b1;

	in_item_t pending_items [$];
	out_item_t pixels_due [$];
	int errors = 0;
	int send_idle = 9, recv_idle = 67;
	bit in_took = 1'b0;
	bit hold_req = 1'b0, hold_ack = 1'b0;
	int stall_left = 0;

	function automatic int unsigned dim_eff(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
		return 32'(v);
	endfunction

	function automatic void clear_cells();
		for (int i = 0; i < CELLS; i++) begin
			red_acc[i] = '0;
			grn_acc[i] = '0;
			blu_acc[i] = '0;
			hit_acc[i] = '0;
		end
		row_pos = 0;
		col_pos = 0;
		rd_pos = 0;
	endfunction

	function automatic void add_to_cell(int unsigned idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		if (idx >= CELLS) return;
		red_acc[idx] = red_acc[idx] + r;
		grn_acc[idx] = grn_acc[idx] + g;
		blu_acc[idx] = blu_acc[idx] + b;
		hit_acc[idx] = hit_acc[idx] + 1'b1;
	endfunction

	function automatic void accumulate_pixel(logic [PIX_W-1:0] pix);
		int unsigned sr, sc, dr, dc, ir, ic, tr, tc;
		logic [7:0] r, g, b;
		sr = dim_eff(m_src_rows);
		sc = dim_eff(m_src_cols);
		dr = dim_eff(m_dst_rows);
		dc = dim_eff(m_dst_cols);
		if (row_pos >= sr) return;
		if (col_pos >= sc) begin
			col_pos = 0;
			row_pos++;
			return;
		end
		if (m_color) begin
			r = pix[23:16];
			g = pix[15:8];
			b = pix[7:0];
		end else begin
			r = pix[7:0];
			g = '0;
			b = '0;
		end
		ir = row_pos * dr / sr;
		ic = col_pos * dc / sc;
		add_to_cell(ir * dc + ic, r, g, b);
		if (dr > sr || dc > sc) begin
			tr = (row_pos + 1) * dr / sr;
			tc = (col_pos + 1) * dc / sc;
			for (int unsigned zr = ir; zr < tr && zr < dr; zr++)
				for (int unsigned zc = ic; zc < tc && zc < dc; zc++)
					if (zr != ir || zc != ic)
						add_to_cell(zr * dc + zc, r, g, b);
		end
		col_pos++;
		if (col_pos >= sc) begin
			col_pos = 0;
			row_pos++;
		end
	endfunction

	function automatic logic [7:0] chan_avg(logic [SUM_W-1:0] s, logic [CNT_W-1:0] n);
		int unsigned q;
		q = s / n;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic out_item_t average_cell();
		out_item_t o;
		int unsigned total, idx;
		o = '0;
		total = dim_eff(m_dst_rows) * dim_eff(m_dst_cols);
		idx = rd_pos;
		if (idx >= total || idx >= CELLS) begin
			o.out_last = 1'b1;
		end else begin
			o.out_last = (idx + 1 == total);
			if (hit_acc[idx] != 0) begin
				if (m_color)
					o.out_pixel = {chan_avg(red_acc[idx], hit_acc[idx]),
						chan_avg(grn_acc[idx], hit_acc[idx]),
						chan_avg(blu_acc[idx], hit_acc[idx])};
				else
					o.out_pixel = {16'd0, chan_avg(red_acc[idx], hit_acc[idx])};
			end
			rd_pos = (idx + 1) & 20'hFFFFF;
		end
		if (o.out_last)
			clear_cells();
		return o;
	endfunction

	// check results, then predict from the input transfer at the same edge
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pixels_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result pixel=%h last=%b",
							out_data.out_pixel, out_data.out_last);
				end else begin
					want = pixels_due.pop_front();
					if (want.out_pixel !== out_data.out_pixel ||
							want.out_last !== out_data.out_last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: pixel exp %h got %h, last exp %b got %b",
								want.out_pixel, out_data.out_pixel,
								want.out_last, out_data.out_last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.opcode == OP_LOAD)
					accumulate_pixel(in_data.pixel_value);
				else
					pixels_due.push_back(average_cell());
			end
		end
		in_took <= in_valid && !in_stall;
	end

	// driver: hold a stalled transfer, otherwise offer the next item
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_took)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			stall_left <= 3000;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || pixels_due.size() != 0)
			@(posedge clk);
		// loads give no result; let the last one and any clearing pass finish
		repeat (600) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SRC_ROWS: m_src_rows = val;
			REG_SRC_COLS: m_src_cols = val;
			REG_DST_ROWS: m_dst_rows = val;
			REG_DST_COLS: m_dst_cols = val;
			REG_COLOR_MODE: m_color = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(int sr, int sc, int dr, int dc, bit color);
		write_reg(REG_SRC_ROWS, DIM_W'(sr));
		write_reg(REG_SRC_COLS, DIM_W'(sc));
		write_reg(REG_DST_ROWS, DIM_W'(dr));
		write_reg(REG_DST_COLS, DIM_W'(dc));
		write_reg(REG_COLOR_MODE, DIM_W'(color));
	endtask

	task automatic push_load(logic [PIX_W-1:0] pix);
		in_item_t it;
		it.opcode = OP_LOAD;
		it.pixel_value = pix;
		pending_items.push_back(it);
	endtask

	task automatic push_reads(int n);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.opcode = OP_READ;
			it.pixel_value = PIX_W'($urandom());
			pending_items.push_back(it);
		end
	endtask

	initial begin
		int sr, sc, dr, dc, nload, sent;
		clear_cells();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (in_stall) @(posedge clk);

		// downscale 2x2 to one cell with extreme pixels, then a load past the image
		set_geometry(2, 2, 1, 1, 1'b1);
		push_load(24'hFFFFFF);
		push_load(24'h000000);
		push_load(24'hFFFFFF);
		push_load(24'h123456);
		push_load(24'h654321);
		push_reads(1);
		wait_idle();
		// upscale one gray pixel into a 2x3 block
		set_geometry(1, 1, 2, 3, 1'b0);
		push_load(24'hABCDEF);
		push_reads(6);
		wait_idle();
		// cell with no hits
		set_geometry(1, 1, 1, 1, 1'b1);
		push_reads(1);
		wait_idle();
		// shrink the width mid-image: dropped load, then read past the target
		set_geometry(1, 4, 1, 4, 1'b1);
		push_load(24'h808080);
		push_load(24'h7F7F7F);
		push_reads(1);
		wait_idle();
		write_reg(REG_SRC_COLS, 8'd1);
		push_load(24'h00FF00);
		push_load(24'hFF00FF);
		push_reads(1);
		wait_idle();
		write_reg(REG_DST_COLS, 8'd1);
		push_reads(1);
		wait_idle();
		// out-of-range registers: 0 acts as 1, above the maximum acts as 128
		set_geometry(0, 255, 1, 128, 1'b1);
		for (int i = 0; i < 128; i++) push_load(PIX_W'($urandom()));
		push_reads(128);
		wait_idle();
		set_geometry(1, 1, 200, 0, 1'b0);
		push_load(24'hFFFFFF);
		push_reads(128);
		wait_idle();

		// fill the block behind a long receiver hold-off
		set_geometry(3, 3, 6, 6, 1'b1);
		for (int i = 0; i < 9; i++) push_load(PIX_W'($urandom()));
		push_reads(36);
		while (pending_items.size() > 36) @(posedge clk);
		hold_req = ~hold_req;
		wait_idle();

		sent = 0;
		while (sent < 150) begin
			if (sent >= 100) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (sent >= 50) begin
				send_idle = 67;
				recv_idle = 9;
			end
			if ($urandom_range(3) != 0) begin
				sr = $urandom_range(1, 6);
				sc = $urandom_range(1, 6);
				dr = $urandom_range(1, 6);
				dc = $urandom_range(1, 6);
				set_geometry(sr, sc, dr, dc, 1'($urandom_range(1)));
			end
			nload = dim_eff(m_src_rows) * dim_eff(m_src_cols);
			// mostly whole images; some short or with extra loads
			case ($urandom_range(9))
				0: nload = $urandom_range(0, nload);
				1: nload = nload + $urandom_range(1, 3);
				default: ;
			endcase
			for (int i = 0; i < nload; i++) begin
				push_load(PIX_W'($urandom()));
				if ($urandom_range(19) == 0) push_reads(1);
			end
			for (int i = 0; i < dim_eff(m_dst_rows) * dim_eff(m_dst_cols); i++) begin
				push_reads(1);
				if ($urandom_range(19) == 0) push_load(PIX_W'($urandom()));
			end
			sent += pending_items.size();
			wait_idle();
		end

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
